>>> src/prd_pkg.sv
// Shared types, widths and constants of the perspective ray direction core.
package prd_pkg;

   localparam int HALF_VIEW_BITS = 16;
   localparam int BASIS_BITS     = 48;
   localparam int ENTRY_BITS     = 16;
   localparam int LOC_BITS       = 26;
   localparam int LOCAL_FRAC     = 20;
   localparam int BASIS_FRAC     = 14;
   localparam int PROD_BITS      = ENTRY_BITS + LOC_BITS;
   localparam int ACC_BITS       = PROD_BITS + 2;
   localparam int W_BITS         = 30;
   localparam int S_BITS         = 2 * W_BITS;
   localparam int NORM_BITS      = 64;
   localparam int LSH_BITS       = 6;
   localparam int M_BITS         = 32;
   localparam int MANT_FRAC      = 30;
   localparam int T_BITS         = M_BITS + 2;
   localparam int P_BITS         = W_BITS + M_BITS;
   localparam int RP_BITS        = 6;
   localparam int CSR_IDX_BITS   = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HALF_VIEW_X = 3'd0,
      CSR_HALF_VIEW_Y = 3'd1,
      CSR_BASIS_RIGHT = 3'd2,
      CSR_BASIS_UP    = 3'd3,
      CSR_BASIS_BACK  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic [LSH_BITS-1:0]      lsh;
      logic signed [W_BITS-1:0] wx;
      logic signed [W_BITS-1:0] wy;
      logic signed [W_BITS-1:0] wz;
   } ray_tag_type;

   function automatic logic [M_BITS-1:0] seed_value(input logic [1:0] idx);
      logic [M_BITS-1:0] seed;
      case (idx)
         2'd2:    seed = M_BITS'(32'd41878 << 14);
         2'd3:    seed = M_BITS'(32'd35258 << 14);
         default: seed = M_BITS'(32'd55378 << 14);
      endcase
      return seed;
   endfunction

endpackage

>>> src/prd_transform.sv
// Local direction, basis transform and squared length, five stages.
module prd_transform import prd_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  sample_x,
   input  logic signed [COORD_BITS-1:0]  sample_y,
   input  logic [HALF_VIEW_BITS-1:0]     half_view_x,
   input  logic [HALF_VIEW_BITS-1:0]     half_view_y,
   input  logic [BASIS_BITS-1:0]         basis_right,
   input  logic [BASIS_BITS-1:0]         basis_up,
   input  logic [BASIS_BITS-1:0]         basis_back,
   output ray_tag_type                   tag_o,
   output logic [S_BITS-1:0]             s_o
);

   localparam int LS = COORD_BITS - 1 + 12 - LOCAL_FRAC;
   localparam int PB = COORD_BITS + HALF_VIEW_BITS + 2;

   logic signed [HALF_VIEW_BITS:0] hvx_s, hvy_s;
   logic signed [PB-1:0]           px, py;
   logic signed [LOC_BITS-1:0]     lx_in, ly_in, lx_ff, ly_ff;
   logic                           v1_ff, v2_ff;
   logic signed [PROD_BITS-1:0]    pr_in [3];
   logic signed [PROD_BITS-1:0]    pu_in [3];
   logic signed [PROD_BITS-1:0]    pr_ff [3];
   logic signed [PROD_BITS-1:0]    pu_ff [3];
   logic signed [ACC_BITS-1:0]     acc [3];
   logic signed [W_BITS-1:0]       w_in [3];
   ray_tag_type                    tag3_in, tag3_ff, tag4_ff, tag5_ff;
   logic [W_BITS-1:0]              mag [3];
   logic [S_BITS-1:0]              sq_in [3];
   logic [S_BITS-1:0]              sq_ff [3];
   logic [S_BITS-1:0]              s_in, s_ff;

   assign hvx_s = {1'b0, half_view_x};
   assign hvy_s = {1'b0, half_view_y};
   assign px    = sample_x * hvx_s;
   assign py    = -(sample_y * hvy_s);
   assign lx_in = LOC_BITS'(px >>> LS);
   assign ly_in = LOC_BITS'(py >>> LS);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pr_in[i] = $signed(basis_right[ENTRY_BITS*i +: ENTRY_BITS]) * lx_ff;
         pu_in[i] = $signed(basis_up[ENTRY_BITS*i +: ENTRY_BITS]) * ly_ff;
         acc[i]   = ACC_BITS'(pr_ff[i]) + ACC_BITS'(pu_ff[i])
                  - (ACC_BITS'($signed(basis_back[ENTRY_BITS*i +: ENTRY_BITS])) <<< LOCAL_FRAC);
         w_in[i]  = W_BITS'(acc[i] >>> BASIS_FRAC);
      end
   end

   always_comb begin
      tag3_in.valid = v2_ff;
      tag3_in.zero  = 1'b0;
      tag3_in.lsh   = '0;
      tag3_in.wx    = w_in[0];
      tag3_in.wy    = w_in[1];
      tag3_in.wz    = w_in[2];
   end

   always_comb begin
      mag[0] = tag3_ff.wx[W_BITS-1] ? W_BITS'(-tag3_ff.wx) : W_BITS'(tag3_ff.wx);
      mag[1] = tag3_ff.wy[W_BITS-1] ? W_BITS'(-tag3_ff.wy) : W_BITS'(tag3_ff.wy);
      mag[2] = tag3_ff.wz[W_BITS-1] ? W_BITS'(-tag3_ff.wz) : W_BITS'(tag3_ff.wz);
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = mag[i] * mag[i];
      end
   end

   assign s_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
         tag5_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff   <= in_valid;
         lx_ff   <= lx_in;
         ly_ff   <= ly_in;
         v2_ff   <= v1_ff;
         pr_ff   <= pr_in;
         pu_ff   <= pu_in;
         tag3_ff <= tag3_in;
         sq_ff   <= sq_in;
         tag4_ff <= tag3_ff;
         s_ff    <= s_in;
         tag5_ff <= tag4_ff;
      end
   end

   assign tag_o = tag5_ff;
   assign s_o   = s_ff;

endmodule

>>> src/prd_normalize.sv
// Even-shift normalization of the squared length, two stages.
module prd_normalize import prd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  ray_tag_type       tag_i,
   input  logic [S_BITS-1:0] s_i,
   output ray_tag_type       tag_o,
   output logic [M_BITS-1:0] m_o
);

   logic [NORM_BITS-1:0] v1_in, v1_ff, v2_in, v2_ff;
   logic [LSH_BITS-1:0]  l1_in, l2_in;
   ray_tag_type          tag1_ff, tag2_ff, tag1_in, tag2_in;

   always_comb begin
      v1_in = NORM_BITS'(s_i);
      l1_in = '0;
      if (v1_in[63:32] == '0) begin
         v1_in = v1_in << 32;
         l1_in = l1_in + LSH_BITS'(32);
      end
      if (v1_in[63:48] == '0) begin
         v1_in = v1_in << 16;
         l1_in = l1_in + LSH_BITS'(16);
      end
      if (v1_in[63:56] == '0) begin
         v1_in = v1_in << 8;
         l1_in = l1_in + LSH_BITS'(8);
      end
      tag1_in      = tag_i;
      tag1_in.lsh  = l1_in;
      tag1_in.zero = (s_i == '0);
   end

   always_comb begin
      v2_in = v1_ff;
      l2_in = tag1_ff.lsh;
      if (v2_in[63:60] == '0) begin
         v2_in = v2_in << 4;
         l2_in = l2_in + LSH_BITS'(4);
      end
      if (v2_in[63:62] == '0) begin
         v2_in = v2_in << 2;
         l2_in = l2_in + LSH_BITS'(2);
      end
      tag2_in     = tag1_ff;
      tag2_in.lsh = l2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff   <= v1_in;
         tag1_ff <= tag1_in;
         v2_ff   <= v2_in;
         tag2_ff <= tag2_in;
      end
   end

   assign tag_o = tag2_ff;
   assign m_o   = v2_ff[NORM_BITS-1 -: M_BITS];

endmodule

>>> src/prd_rsqrt.sv
// Reciprocal square root of the mantissa, three stages per Newton step.
module prd_rsqrt import prd_pkg::*; #(
   parameter int RSQRT_ITERATIONS = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  ray_tag_type       tag_i,
   input  logic [M_BITS-1:0] m_i,
   output ray_tag_type       tag_o,
   output logic [M_BITS-1:0] y_o
);

   localparam logic [T_BITS-1:0] THREE = T_BITS'(3) << MANT_FRAC;

   logic [M_BITS-1:0] m_q   [RSQRT_ITERATIONS+1];
   logic [M_BITS-1:0] y_q   [RSQRT_ITERATIONS+1];
   ray_tag_type       tag_q [RSQRT_ITERATIONS+1];

   assign m_q[0]   = m_i;
   assign y_q[0]   = seed_value(m_i[M_BITS-1 -: 2]);
   assign tag_q[0] = tag_i;

   for (genvar k = 0; k < RSQRT_ITERATIONS; k++) begin : g_step
      logic [2*M_BITS-1:0] y_sq, m_y2, y_d;
      logic [T_BITS-1:0]   t;
      logic [M_BITS-1:0]   d;
      logic [M_BITS-1:0]   a_m_ff, a_y_ff, a_y2_ff;
      logic [M_BITS-1:0]   b_m_ff, b_y_ff, b_d_ff;
      logic [M_BITS-1:0]   c_m_ff, c_y_ff;
      ray_tag_type         a_tag_ff, b_tag_ff, c_tag_ff;

      assign y_sq = y_q[k] * y_q[k];
      assign m_y2 = a_m_ff * a_y2_ff;
      assign t    = T_BITS'(m_y2 >> MANT_FRAC);
      assign d    = (t >= THREE) ? '0 : M_BITS'(THREE - t);
      assign y_d  = b_y_ff * b_d_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            a_tag_ff.valid <= 1'b0;
            b_tag_ff.valid <= 1'b0;
            c_tag_ff.valid <= 1'b0;
         end else if (en) begin
            a_m_ff   <= m_q[k];
            a_y_ff   <= y_q[k];
            a_y2_ff  <= M_BITS'(y_sq >> MANT_FRAC);
            a_tag_ff <= tag_q[k];
            b_m_ff   <= a_m_ff;
            b_y_ff   <= a_y_ff;
            b_d_ff   <= d;
            b_tag_ff <= a_tag_ff;
            c_m_ff   <= b_m_ff;
            c_y_ff   <= M_BITS'(y_d >> (MANT_FRAC + 1));
            c_tag_ff <= b_tag_ff;
         end
      end

      assign m_q[k+1]   = c_m_ff;
      assign y_q[k+1]   = c_y_ff;
      assign tag_q[k+1] = c_tag_ff;
   end

   assign tag_o = tag_q[RSQRT_ITERATIONS];
   assign y_o   = y_q[RSQRT_ITERATIONS];

endmodule

>>> src/prd_scale.sv
// Scale by the reciprocal length, round and saturate, two stages.
module prd_scale import prd_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  ray_tag_type                  tag_i,
   input  logic [M_BITS-1:0]            y_i,
   output logic                         out_valid,
   output logic signed [COORD_BITS-1:0] dir_x,
   output logic signed [COORD_BITS-1:0] dir_y,
   output logic signed [COORD_BITS-1:0] dir_z
);

   localparam logic [COORD_BITS-1:0] MAX_CODE = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] MIN_CODE = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [NORM_BITS-1:0]  HALF     = NORM_BITS'(1) << (COORD_BITS - 1);
   localparam int                    RP_BASE  = 63 - COORD_BITS;

   logic signed [W_BITS-1:0] w [3];
   logic [W_BITS-1:0]        mag [3];
   logic [P_BITS-1:0]        p_in [3];
   logic [P_BITS-1:0]        p_ff [3];
   logic [2:0]               neg_ff;
   logic                     zero_ff, v1_ff, v2_ff;
   logic [RP_BITS-1:0]       rp_in, rp_ff;
   logic [NORM_BITS-1:0]     rnd, q [3];
   logic [COORD_BITS-1:0]    code_in [3];
   logic [COORD_BITS-1:0]    code_ff [3];

   assign w[0]  = tag_i.wx;
   assign w[1]  = tag_i.wy;
   assign w[2]  = tag_i.wz;
   assign rp_in = RP_BITS'(RP_BASE - int'(tag_i.lsh[LSH_BITS-1:1]));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]  = w[i][W_BITS-1] ? W_BITS'(-w[i]) : W_BITS'(w[i]);
         p_in[i] = mag[i] * y_i;
      end
   end

   always_comb begin
      rnd = (rp_ff == '0) ? '0 : (NORM_BITS'(1) << (rp_ff - RP_BITS'(1)));
      for (int i = 0; i < 3; i++) begin
         q[i] = (NORM_BITS'({p_ff[i], 1'b0}) + rnd) >> rp_ff;
         if (zero_ff) begin
            code_in[i] = '0;
         end else if (!neg_ff[i]) begin
            code_in[i] = (q[i] >= HALF) ? MAX_CODE : q[i][COORD_BITS-1:0];
         end else begin
            code_in[i] = (q[i] >= HALF) ? MIN_CODE : COORD_BITS'(-q[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff   <= tag_i.valid;
         p_ff    <= p_in;
         neg_ff  <= {w[2][W_BITS-1], w[1][W_BITS-1], w[0][W_BITS-1]};
         zero_ff <= tag_i.zero;
         rp_ff   <= rp_in;
         v2_ff   <= v1_ff;
         code_ff <= code_in;
      end
   end

   assign out_valid = v2_ff;
   assign dir_x     = code_ff[0];
   assign dir_y     = code_ff[1];
   assign dir_z     = code_ff[2];

endmodule

>>> src/perspective_ray_direction_core.sv
// Top level of the perspective ray direction core.
//
//   channel  ports                              direction
//   request  req_valid/req_ready, req_sample_*  in
//   response rsp_valid/rsp_ready, rsp_dir_*     out
//   csr      csr_write_en, csr_index, csr_wdata in
//
// One request per cycle while no response is held; the reciprocal square root
// runs RSQRT_ITERATIONS Newton steps of three multiplies each.
// Reset clears the stage valid bits and loads the identity camera.
// A held response stalls every stage at once; nothing is dropped or repeated.
module perspective_ray_direction_core import prd_pkg::*; #(
   parameter int COORD_BITS       = 16,
   parameter int RSQRT_ITERATIONS = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_sample_x,
   input  logic signed [COORD_BITS-1:0] req_sample_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_dir_x,
   output logic signed [COORD_BITS-1:0] rsp_dir_y,
   output logic signed [COORD_BITS-1:0] rsp_dir_z,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [BASIS_BITS-1:0]        csr_wdata
);

   logic [HALF_VIEW_BITS-1:0] half_view_x_ff, half_view_y_ff;
   logic [BASIS_BITS-1:0]     basis_right_ff, basis_up_ff, basis_back_ff;
   logic                      en;
   ray_tag_type               tag_t, tag_n, tag_r;
   logic [S_BITS-1:0]         s_t;
   logic [M_BITS-1:0]         m_n, y_r;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_view_x_ff <= HALF_VIEW_BITS'(16'h1000);
         half_view_y_ff <= HALF_VIEW_BITS'(16'h1000);
         basis_right_ff <= 48'h0000_0000_4000;
         basis_up_ff    <= 48'h0000_4000_0000;
         basis_back_ff  <= 48'h4000_0000_0000;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HALF_VIEW_X: half_view_x_ff <= csr_wdata[HALF_VIEW_BITS-1:0];
            CSR_HALF_VIEW_Y: half_view_y_ff <= csr_wdata[HALF_VIEW_BITS-1:0];
            CSR_BASIS_RIGHT: basis_right_ff <= csr_wdata;
            CSR_BASIS_UP:    basis_up_ff    <= csr_wdata;
            CSR_BASIS_BACK:  basis_back_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   prd_transform #(.COORD_BITS(COORD_BITS)) u_transform (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .sample_x    (req_sample_x),
      .sample_y    (req_sample_y),
      .half_view_x (half_view_x_ff),
      .half_view_y (half_view_y_ff),
      .basis_right (basis_right_ff),
      .basis_up    (basis_up_ff),
      .basis_back  (basis_back_ff),
      .tag_o       (tag_t),
      .s_o         (s_t)
   );

   prd_normalize u_normalize (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .tag_i (tag_t),
      .s_i   (s_t),
      .tag_o (tag_n),
      .m_o   (m_n)
   );

   prd_rsqrt #(.RSQRT_ITERATIONS(RSQRT_ITERATIONS)) u_rsqrt (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .tag_i (tag_n),
      .m_i   (m_n),
      .tag_o (tag_r),
      .y_o   (y_r)
   );

   prd_scale #(.COORD_BITS(COORD_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .tag_i     (tag_r),
      .y_i       (y_r),
      .out_valid (rsp_valid),
      .dir_x     (rsp_dir_x),
      .dir_y     (rsp_dir_y),
      .dir_z     (rsp_dir_z)
   );

endmodule

>>> dv/tb_perspective_ray_direction_core.sv
// Self-checking testbench for perspective_ray_direction_core: directed table, then random camera phases.
module tb_perspective_ray_direction_core;
   import prd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB        = 16;
   localparam int NEWTON    = 3;
   localparam int LATENCY   = 9 + 3 * NEWTON;
   localparam int PHASES    = 13;
   localparam int PHASE_RAYS = 118;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_UNUSED = CSR_BASIS_BACK + 1;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
   } direction_t;

   typedef struct {
      logic signed [CB-1:0] sx;
      logic signed [CB-1:0] sy;
      bit                   typed;
      direction_t           dir;
   } ray_row_t;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [CB-1:0] req_sample_x;
   logic signed [CB-1:0] req_sample_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [CB-1:0] rsp_dir_x;
   logic signed [CB-1:0] rsp_dir_y;
   logic signed [CB-1:0] rsp_dir_z;
   logic                 csr_write_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [BASIS_BITS-1:0]   csr_wdata;

   bit [15:0] cam_hvx, cam_hvy;
   bit [47:0] cam_basis [3];

   ray_row_t   launch_q [$];
   direction_t dir_expect_q [$];
   int         fail_count, rays_sent, rays_checked, cycle_count, burst_left;

   ray_row_t directed_rays [] = '{
      '{16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, -16'sd32768}},
      '{-16'sd32768, -16'sd32768, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 1'b0, '0},
      '{-16'sd32768, 16'sd32767, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 1'b0, '0},
      '{16'sd1, -16'sd1, 1'b0, '0},
      '{-16'sd1, 16'sd1, 1'b0, '0},
      '{16'sd16384, -16'sd16384, 1'b0, '0},
      '{-16'sd21846, 16'sd5461, 1'b0, '0},
      '{16'sd32767, 16'sd0, 1'b0, '0},
      '{16'sd0, -16'sd32768, 1'b0, '0},
      '{16'sh5555, -16'sh5556, 1'b0, '0}
   };

   perspective_ray_direction_core #(.COORD_BITS(CB), .RSQRT_ITERATIONS(NEWTON)) u_dut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic direction_t predict_direction(logic signed [CB-1:0] sx,
                                                    logic signed [CB-1:0] sy);
      longint loc [3];
      longint world [3];
      longint acc;
      longint unsigned sq, m, y, y2, t, d, mag, p, q;
      longint v;
      int e, sh, h, r;
      longint res [3];
      direction_t o;
      loc[0] = (longint'(sx) * longint'(cam_hvx)) >>> (CB - 1 + 12 - 20);
      loc[1] = (-(longint'(sy) * longint'(cam_hvy))) >>> (CB - 1 + 12 - 20);
      loc[2] = -(longint'(1) <<< 20);
      for (int row = 0; row < 3; row++) begin
         acc = 0;
         for (int col = 0; col < 3; col++)
            acc += longint'($signed(cam_basis[col][16*row +: 16])) * loc[col];
         world[row] = acc >>> 14;
      end
      sq = longint'(world[0] * world[0]) + longint'(world[1] * world[1])
         + longint'(world[2] * world[2]);
      if (sq == 0) return '0;
      e = 63;
      while (e > 0 && !sq[e]) e--;
      sh = e - 30;
      if (sh[0]) sh -= 1;
      m = sh >= 0 ? sq >> sh : sq << (-sh);
      case (m[31:30])
         2'd2:    y = 64'd41878 << 14;
         2'd3:    y = 64'd35258 << 14;
         default: y = 64'd55378 << 14;
      endcase
      for (int i = 0; i < NEWTON; i++) begin
         y2 = (y * y) >> 30;
         t  = (m * y2) >> 30;
         d  = t >= (64'd3 << 30) ? 64'd0 : (64'd3 << 30) - t;
         y  = (y * d) >> 31;
      end
      h = (10 - sh) / 2;
      r = 50 - (CB - 1) - h;
      for (int k = 0; k < 3; k++) begin
         mag = world[k] < 0 ? -world[k] : world[k];
         p = mag * y;
         q = r >= 1 ? (p + (64'd1 << (r - 1))) >> r : p << (-r);
         if (q > (64'd1 << (CB - 1))) q = 64'd1 << (CB - 1);
         v = world[k] < 0 ? -longint'(q) : longint'(q);
         if (v > (longint'(1) <<< (CB - 1)) - 1) v = (longint'(1) <<< (CB - 1)) - 1;
         res[k] = v;
      end
      o.x = res[0][CB-1:0];
      o.y = res[1][CB-1:0];
      o.z = res[2][CB-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      ray_row_t   row;
      direction_t want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            row = launch_q.pop_front();
            dir_expect_q.push_back(row.typed ? row.dir : predict_direction(row.sx, row.sy));
            rays_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (dir_expect_q.size() == 0) begin
               $display("%0t: response with nothing expected: %0d %0d %0d",
                        $time, rsp_dir_x, rsp_dir_y, rsp_dir_z);
               fail_count++;
            end else begin
               want = dir_expect_q.pop_front();
               rays_checked++;
               if (rsp_dir_x !== want.x) begin
                  $display("%0t: dir_x expected %0d actual %0d", $time, want.x, rsp_dir_x);
                  fail_count++;
               end
               if (rsp_dir_y !== want.y) begin
                  $display("%0t: dir_y expected %0d actual %0d", $time, want.y, rsp_dir_y);
                  fail_count++;
               end
               if (rsp_dir_z !== want.z) begin
                  $display("%0t: dir_z expected %0d actual %0d", $time, want.z, rsp_dir_z);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_perspective_ray_direction_core failed");
         $finish;
      end
   end

   // stall pattern: rsp_ready follows a mode picked at random from four
   always @(negedge clock) begin
      int mode;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (cycle_count % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= $urandom_range(0, 1);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((cycle_count / 4) % 2 == 0);
         endcase
      end
   end

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [BASIS_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_HALF_VIEW_X: cam_hvx = data[15:0];
         CSR_HALF_VIEW_Y: cam_hvy = data[15:0];
         CSR_BASIS_RIGHT: cam_basis[0] = data;
         CSR_BASIS_UP:    cam_basis[1] = data;
         CSR_BASIS_BACK:  cam_basis[2] = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [47:0] random_basis();
      if ($urandom_range(0, 3) == 0) return {$urandom(), $urandom()};
      return {16'($signed($urandom_range(0, 32768)) - 16384),
              16'($signed($urandom_range(0, 32768)) - 16384),
              16'($signed($urandom_range(0, 32768)) - 16384)};
   endfunction

   task automatic load_camera(int phase);
      logic [15:0] hx, hy;
      logic [47:0] br, bu, bb;
      hx = $urandom_range(1000, 14000);
      hy = $urandom_range(1000, 14000);
      br = random_basis();
      bu = random_basis();
      bb = random_basis();
      case (phase)
         1: begin hx = '1; hy = '1; br = '1; bu = '1; bb = '1; end
         2: begin
            hx = '0; hy = '0;
            br = {3{16'h8000}}; bu = {3{16'h8000}}; bb = {3{16'h8000}};
         end
         3: begin br = '0; bu = '0; bb = {16'hC000, 32'h0}; end
         4: begin br = '0; bu = '0; bb = '0; end
         5: begin hx = 16'hFFFF; hy = 16'h0001; br = {3{16'h7FFF}}; bu = {3{16'h7FFF}}; end
         6: begin br = 48'd16384; bu = 48'd16384 << 16; bb = 48'd16384 << 32; end
         default: ;
      endcase
      write_csr(CSR_HALF_VIEW_X, {$urandom(), 16'h0} | hx);
      write_csr(CSR_HALF_VIEW_Y, {$urandom(), 16'h0} | hy);
      write_csr(CSR_BASIS_RIGHT, br);
      write_csr(CSR_BASIS_UP, bu);
      write_csr(CSR_BASIS_BACK, bb);
      for (logic [CSR_IDX_BITS:0] i = CSR_FIRST_UNUSED; i < (1 << CSR_IDX_BITS); i++)
         write_csr(i[CSR_IDX_BITS-1:0], {$urandom(), $urandom()});
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_ray(ray_row_t row);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_sample_x <= row.sx;
      req_sample_y <= row.sy;
      launch_q.push_back(row);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (dir_expect_q.size() != 0 || launch_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic signed [CB-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         2:       return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
         3:       return 16'sd0;
         default: return CB'($urandom());
      endcase
   endfunction

   initial begin
      ray_row_t row;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample_x = '0;
      req_sample_y = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_HALF_VIEW_X;
      csr_wdata    = '0;
      cam_hvx      = 16'd4096;
      cam_hvy      = 16'd4096;
      cam_basis[0] = 48'd16384;
      cam_basis[1] = 48'd16384 << 16;
      cam_basis[2] = 48'd16384 << 32;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rays[i]) send_ray(directed_rays[i]);
      drain();
      for (int phase = 1; phase <= PHASES; phase++) begin
         load_camera(phase);
         row = '{16'sd0, 16'sd0, 1'b0, '0};
         send_ray(row);
         for (int n = 0; n < PHASE_RAYS; n++) begin
            row.sx = random_sample();
            row.sy = random_sample();
            send_ray(row);
         end
         drain();
      end
      $display("Covered %0d rays over %0d camera settings, %0d responses checked.",
               rays_sent, PHASES + 1, rays_checked);
      if (fail_count == 0) begin
         $display("tb_perspective_ray_direction_core passed");
      end else begin
         $display("tb_perspective_ray_direction_core failed");
      end
      $finish;
   end

endmodule

>>> files.f
src/prd_pkg.sv
src/prd_transform.sv
src/prd_normalize.sv
src/prd_rsqrt.sv
src/prd_scale.sv
src/perspective_ray_direction_core.sv
dv/tb_perspective_ray_direction_core.sv
